>>> design/fm_phase_discriminator_assert.svh
// Assertion macros for the FM phase discriminator.
`ifndef FM_PHASE_DISCRIMINATOR_ASSERT_SVH
`define FM_PHASE_DISCRIMINATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FMPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FMPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fmpd_pkg.sv
// Package: controller states, angle constants and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
package fmpd_pkg;

    localparam int PHASE_W    = 16;
    localparam int ANGLE_W    = 32;
    localparam int GUARD_BITS = 8;
    localparam int ATAN_LEN   = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_ROUND,
        ST_EMIT
    } fmpd_state_t;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] val;
        unique case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

    // one-bit full adder, returns {carry, sum}
    function automatic logic [1:0] full_add(input logic a, input logic b, input logic c);
        return {(a & b) | (a & c) | (b & c), a ^ b ^ c};
    endfunction

endpackage
`default_nettype wire

>>> design/fm_phase_discriminator.sv
// Polar FM discriminator: bit-serial vectoring CORDIC phase and phase difference.
// One item at a time: s_tready is high only in idle, so the next item is taken only after
//   the previous one has left through emit. A prep pass comes first, then each CORDIC step is
//   one pass over the W bits through the single bit-serial adder slice, W = max(SAMPLE_BITS
//   + 11, 32); emit stalls while the output register holds an item not yet taken.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) clears the controller, output valid and previous phase.
`timescale 1ns / 1ps
`default_nettype none
`include "fm_phase_discriminator_assert.svh"
module fm_phase_discriminator
    import fmpd_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [SAMPLE_BITS-1:0] sample_first, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_second,
    // zero fill above
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  wire logic                                  s_tlast,   // block_end
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [PHASE_W-1:0]                         m_tdata,   // [15:0] freq_sample
    output logic                                       m_tlast    // block_end_out
);

    // working width: scaled input, negation, CORDIC gain and margin; at least one angle word
    localparam int W      = (SAMPLE_BITS + 11 > ANGLE_W) ? SAMPLE_BITS + 11 : ANGLE_W;
    localparam int IDX_W  = $clog2(W);
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int EXT_W  = W - SAMPLE_BITS - GUARD_BITS;

    fmpd_state_t state_reg, state_next;

    logic [W-1:0]       x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               x_sgn_reg, x_sgn_next, y_sgn_reg, y_sgn_next;
    logic               cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic               neg_reg, neg_next, zero_reg, zero_next, last_reg, last_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [STEP_W-1:0]  iter_reg, iter_next;
    logic [PHASE_W-1:0] phase_reg, phase_next, prev_phase_reg, prev_phase_next;
    logic [PHASE_W-1:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next, m_valid_reg, m_valid_next;

    // controller decodes
    logic load_en, prep_en, iter_en, round_en, emit_en;

    logic [SAMPLE_BITS-1:0] in_first, in_second;
    logic                   last_bit, last_step, first_bit, tap_in_range, dir;
    logic [IDX_W-1:0]       tap_idx;
    logic [IDX_W:0]         tap_sum;
    logic [W-1:0]           atan_word;
    logic                   xs_bit, ys_bit, atan_bit;
    logic                   xa, xb, xc, ya, yb, yc, za, zb, zc;
    logic [1:0]             x_fa, y_fa, z_fa;
    logic                   out_free;

    assign in_first  = s_tdata[SAMPLE_BITS-1:0];
    assign in_second = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    assign last_bit  = (k_reg == IDX_W'(W - 1));
    assign last_step = (iter_reg == STEP_W'(CORDIC_STEPS - 1));
    assign first_bit = (k_reg == '0);
    assign out_free  = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PREP;
            ST_PREP:  if (last_bit) state_next = ST_ITER;
            ST_ITER:  if (last_bit && last_step) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_tready = 1'b0;
        load_en  = 1'b0;
        prep_en  = 1'b0;
        iter_en  = 1'b0;
        round_en = 1'b0;
        emit_en  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                load_en  = s_tvalid;
            end
            ST_PREP:  prep_en  = 1'b1;
            ST_ITER:  iter_en  = 1'b1;
            ST_ROUND: round_en = 1'b1;
            ST_EMIT:  emit_en  = out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // shifted operand taps: orig bit k+i sits at position i until it runs past the sign
    assign tap_idx      = IDX_W'(iter_reg);
    assign tap_sum      = {1'b0, k_reg} + (IDX_W + 1)'(iter_reg);
    assign tap_in_range = (tap_sum < (IDX_W + 1)'(W));
    assign xs_bit       = tap_in_range ? x_reg[tap_idx] : x_sgn_reg;
    assign ys_bit       = tap_in_range ? y_reg[tap_idx] : y_sgn_reg;
    assign atan_word    = W'(atan_turn(5'(iter_reg)));
    assign atan_bit     = atan_word[k_reg];
    assign dir          = y_sgn_reg;   // 1: y negative, rotate the other way

    // serial adder operands; prep pass negates x and y when x is negative
    always_comb begin
        if (prep_en) begin
            xa = x_reg[0] ^ neg_reg;
            xb = 1'b0;
            xc = first_bit ? neg_reg : cx_reg;
            ya = y_reg[0] ^ neg_reg;
            yb = 1'b0;
            yc = first_bit ? neg_reg : cy_reg;
        end else begin
            xa = x_reg[0];
            xb = ys_bit ^ dir;
            xc = first_bit ? dir : cx_reg;
            ya = y_reg[0];
            yb = xs_bit ^ ~dir;
            yc = first_bit ? ~dir : cy_reg;
        end
        za = z_reg[0];
        zb = atan_bit ^ dir;
        zc = first_bit ? dir : cz_reg;
    end

    assign x_fa = full_add(xa, xb, xc);
    assign y_fa = full_add(ya, yb, yc);
    assign z_fa = full_add(za, zb, zc);

    // datapath next values
    always_comb begin
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        x_sgn_next      = x_sgn_reg;
        y_sgn_next      = y_sgn_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        last_next       = last_reg;
        k_next          = k_reg;
        iter_next       = iter_reg;
        phase_next      = phase_reg;
        prev_phase_next = prev_phase_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (load_en) begin
            x_next     = {{EXT_W{in_second[SAMPLE_BITS-1]}}, in_second, GUARD_BITS'(0)};
            y_next     = {{EXT_W{in_first[SAMPLE_BITS-1]}}, in_first, GUARD_BITS'(0)};
            x_sgn_next = in_second[SAMPLE_BITS-1];
            y_sgn_next = in_first[SAMPLE_BITS-1];
            neg_next   = in_second[SAMPLE_BITS-1];
            zero_next  = (in_first == '0) && (in_second == '0);
            last_next  = s_tlast;
            // negative x: start the angle at a half turn
            z_next     = W'({in_second[SAMPLE_BITS-1], (ANGLE_W - 1)'(0)});
            k_next     = '0;
            iter_next  = '0;
        end

        if (prep_en || iter_en) begin
            x_next  = {x_fa[0], x_reg[W-1:1]};
            y_next  = {y_fa[0], y_reg[W-1:1]};
            cx_next = x_fa[1];
            cy_next = y_fa[1];
            k_next  = last_bit ? '0 : k_reg + 1'b1;
            if (last_bit) begin
                x_sgn_next = x_fa[0];
                y_sgn_next = y_fa[0];
            end
        end

        if (iter_en) begin
            z_next  = {z_fa[0], z_reg[W-1:1]};
            cz_next = z_fa[1];
            if (last_bit) begin
                iter_next = last_step ? '0 : iter_reg + 1'b1;
            end
        end

        if (round_en) begin
            phase_next = zero_reg ? '0
                       : z_reg[ANGLE_W-1:PHASE_W] + PHASE_W'(z_reg[PHASE_W-1]);
        end

        if (emit_en) begin
            m_data_next     = phase_reg - prev_phase_reg;
            m_last_next     = last_reg;
            m_valid_next    = 1'b1;
            prev_phase_next = phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            iter_reg       <= '0;
            m_valid_reg    <= 1'b0;
            prev_phase_reg <= '0;
        end else begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            iter_reg       <= iter_next;
            m_valid_reg    <= m_valid_next;
            prev_phase_reg <= prev_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        x_sgn_reg  <= x_sgn_next;
        y_sgn_reg  <= y_sgn_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        last_reg   <= last_next;
        phase_reg  <= phase_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `FMPD_ASSERT_NOW(a_idle_counters_parked, aclk, aresetn,
        state_reg == ST_IDLE, (k_reg == '0) && (iter_reg == '0),
        "bit or step counter not parked in idle")

    `FMPD_ASSERT_NEXT(a_iter_runs_full, aclk, aresetn,
        (state_reg == ST_ITER) && !(last_bit && last_step), state_reg == ST_ITER,
        "CORDIC left before the last bit of the last step")

    `FMPD_ASSERT_NEXT(a_zero_vector_phase, aclk, aresetn,
        (state_reg == ST_ROUND) && zero_reg, phase_reg == '0,
        "zero vector did not give phase zero")

endmodule
`default_nettype wire

>>> tb/fm_phase_discriminator_tb.sv
// Self-checking testbench for the polar FM discriminator: predicted CORDIC phase differences.
`timescale 1ns / 1ps
module fm_phase_discriminator_tb;

    localparam int SAMPLE_W       = 16;
    localparam int CORDIC_ITERS   = 16;
    localparam int DATA_W         = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int IDLE_PCT       = 29;
    localparam int DRAIN_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    // atan(2^-i), 2^32 = one turn
    localparam logic [31:0] ARCTAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [fmpd_pkg::PHASE_W-1:0] freq;
        logic                         block_end;
    } demod_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [DATA_W-1:0]            s_tdata;   // [15:0] sample_first, [31:16] sample_second
    logic                         s_tlast;   // block_end
    logic                         m_tvalid;
    logic                         m_tready;
    logic [fmpd_pkg::PHASE_W-1:0] m_tdata;   // [15:0] freq_sample
    logic                         m_tlast;   // block_end_out

    demod_t      pending_demod[$];
    logic [15:0] prev_phase = 16'd0;
    int          mismatch_count = 0;
    bit          quiet_stretch = 1'b0;

    fm_phase_discriminator #(
        .SAMPLE_BITS  (SAMPLE_W),
        .CORDIC_STEPS (CORDIC_ITERS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Vectoring CORDIC phase, 16-bit binary angle, 32768 = pi
    function automatic logic [15:0] cordic_phase(input logic signed [15:0] y_in,
                                                 input logic signed [15:0] x_in);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        logic [31:0] acc;
        int          i;
        if (x_in == 0 && y_in == 0)
            return 16'd0;
        vx  = longint'(x_in) * 256;
        vy  = longint'(y_in) * 256;
        acc = 32'd0;
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            acc = 32'h8000_0000;
        end
        for (i = 0; i < CORDIC_ITERS && i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ARCTAN_TURNS[i];
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ARCTAN_TURNS[i];
            end
        end
        acc = acc + 32'h0000_8000;
        return acc[31:16];
    endfunction

    task automatic predict_demod(input logic signed [15:0] y_in, input logic signed [15:0] x_in,
                                 input logic blk_end);
        logic [15:0] phase;
        demod_t      want;
        phase          = cordic_phase(y_in, x_in);
        want.freq      = phase - prev_phase;
        want.block_end = blk_end;
        prev_phase     = phase;
        pending_demod.push_back(want);
    endtask

    task automatic send_sample(input logic signed [15:0] y_in, input logic signed [15:0] x_in,
                               input logic blk_end);
        if (idle_now()) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (idle_now());
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {x_in, y_in};
        s_tlast  <= blk_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_demod(y_in, x_in, blk_end);
    endtask

    // Axes, quadrant corners, tiny vectors and the exact half-turn step.
    task automatic test_directed();
        send_sample(16'sd0, 16'sd0, 1'b0);            // zero vector
        send_sample(16'sd0, 16'sd1, 1'b1);
        send_sample(16'sd0, -16'sd1, 1'b0);           // negative x on the axis
        send_sample(16'sd0, 16'sd32767, 1'b0);
        send_sample(16'sd0, -16'sd32768, 1'b1);       // +pi step wraps to -32768
        send_sample(16'sd32767, 16'sd0, 1'b0);
        send_sample(-16'sd32768, 16'sd0, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, 1'b1);
        send_sample(16'sd32767, -16'sd32768, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, 1'b0);
        send_sample(16'sd1, 16'sd1, 1'b0);
        send_sample(-16'sd1, -16'sd1, 1'b1);
        send_sample(16'sd1, -16'sd1, 1'b0);
        send_sample(-16'sd1, 16'sd1, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(-16'sd1, -16'sd32768, 1'b0);
        send_sample(16'sd1, -16'sd32768, 1'b0);       // just across the branch cut
        send_sample(16'sd0, 16'sd0, 1'b1);
    endtask

    // FM-like phasor blocks: fixed amplitude, random rate, block_end on the last one.
    task automatic test_phasor_blocks(input int n_items);
        int  sent;
        int  blk_len;
        int  k;
        real amp;
        real ang;
        real rate;
        logic signed [15:0] y_v;
        logic signed [15:0] x_v;
        sent = 0;
        while (sent < n_items) begin
            blk_len = $urandom_range(8, 64);
            if (blk_len > n_items - sent)
                blk_len = n_items - sent;
            if ($urandom_range(9) == 0)
                amp = $urandom_range(1, 60);
            else
                amp = $urandom_range(1000, 32767);
            ang = $urandom_range(0, 62831) / 10000.0;
            if ($urandom_range(7) == 0)
                rate = ($urandom_range(1) ? 1.0 : -1.0) * (3.1 + $urandom_range(0, 41) / 1000.0);
            else
                rate = ($urandom_range(0, 62000) / 10000.0) - 3.1;
            for (k = 0; k < blk_len; k++) begin
                y_v = 16'($rtoi(amp * $sin(ang)));
                x_v = 16'($rtoi(amp * $cos(ang)));
                send_sample(y_v, x_v, k == blk_len - 1);
                ang = ang + rate;
            end
            sent += blk_len;
        end
    endtask

    // Unstructured items: full-range, tiny and on-axis vectors, random block_end.
    task automatic test_noise(input int n_items);
        int n;
        logic signed [15:0] y_v;
        logic signed [15:0] x_v;
        for (n = 0; n < n_items; n++) begin
            case ($urandom_range(3))
                0: begin
                    y_v = 16'($urandom_range(0, 7)) - 16'sd4;
                    x_v = 16'($urandom_range(0, 7)) - 16'sd4;
                end
                1: begin
                    y_v = $urandom_range(1) ? 16'sd0 : 16'($urandom);
                    x_v = (y_v != 0) ? 16'sd0 : 16'($urandom);
                end
                default: begin
                    y_v = 16'($urandom);
                    x_v = 16'($urandom);
                end
            endcase
            send_sample(y_v, x_v, $urandom_range(15) == 0);
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        quiet_stretch = 1'b1;
        test_phasor_blocks(n_items);
        quiet_stretch = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        demod_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_demod.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item: expected none, actual freq %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = pending_demod.pop_front();
                if (m_tdata !== want.freq) begin
                    mismatch_count++;
                    $display("%0t: freq_sample: expected %h, actual %h",
                             $time, want.freq, m_tdata);
                end
                if (m_tlast !== want.block_end) begin
                    mismatch_count++;
                    $display("%0t: block_end_out: expected %b, actual %b",
                             $time, want.block_end, m_tlast);
                end
            end
        end
    end

    // cycles without any accepted item on either side
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_phasor_blocks(400);
        test_noise(200);
        test_back_to_back(120);
        test_phasor_blocks(120);

        s_tvalid <= 1'b0;
        while (pending_demod.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
